@@ rtl/core/hcbd_pkg.sv @@
// Shared types and constants for the chunked body decoder.
// Holds the phase encoding, the error codes, the result word and the hex digit decode.
// No dependencies.
package hcbd_pkg;

    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;

    localparam logic [2:0] ERR_NONE        = 3'd0;
    localparam logic [2:0] ERR_SIZE_MISS   = 3'd1;
    localparam logic [2:0] ERR_SIZE_CHAR   = 3'd2;
    localparam logic [2:0] ERR_SIZE_OVF    = 3'd3;
    localparam logic [2:0] ERR_CR_NO_LF    = 3'd4;
    localparam logic [2:0] ERR_NO_DATA_CR  = 3'd5;
    localparam logic [2:0] ERR_NO_LAST_CR  = 3'd6;

    typedef enum logic [9:0] {
        PH_FIRST    = 10'b00_0000_0001,
        PH_SIZE     = 10'b00_0000_0010,
        PH_SIZE_CR  = 10'b00_0000_0100,
        PH_CHUNK    = 10'b00_0000_1000,
        PH_DATA_END = 10'b00_0001_0000,
        PH_DATA_CR  = 10'b00_0010_0000,
        PH_LAST_LF  = 10'b00_0100_0000,
        PH_LAST_CR  = 10'b00_1000_0000,
        PH_DONE     = 10'b01_0000_0000,
        PH_ERROR    = 10'b10_0000_0000
    } t_phase;

    typedef struct packed {
        logic       data_valid;
        logic [7:0] data_byte;
        logic       chunk_end;
        logic       body_done;
        logic [2:0] error_code;
        logic       ignored;
    } t_result;

    // bit 4 set: not a hex digit; bits 3:0: digit value
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        v = 5'd16;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = {1'b0, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            v = {1'b0, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            v = {1'b0, 4'(c - 8'h37)};
        end
        return v;
    endfunction

endpackage

@@ rtl/core/hcbd_in_stage.sv @@
// Input register of the chunked body decoder.
// Captures one stream word per cycle while it is empty or its word is taken; depends on nothing else.
module hcbd_in_stage (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_byte,
    output logic       o_ready,
    input  logic       i_advance,
    output logic       o_valid,
    output logic [7:0] o_byte
);

    logic       r_valid;
    logic [7:0] r_byte;

    assign o_ready = !r_valid || i_advance;
    assign o_valid = r_valid;
    assign o_byte  = r_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_byte <= i_byte;
        end
    end

endmodule

@@ rtl/core/hcbd_fsm.sv @@
// Parser state machine of the chunked body decoder.
// Decodes the size line, counts payload, checks CRLF framing; uses hcbd_pkg.
module hcbd_fsm #(
    parameter int SIZE_BITS = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [7:0]        i_byte,
    output hcbd_pkg::t_result o_result
);

    hcbd_pkg::t_phase       r_phase, n_phase;
    logic [SIZE_BITS-1:0]   r_size, n_size;
    logic [2:0]             r_err, n_err;
    logic [4:0]             hex;
    hcbd_pkg::t_result      res;

    assign hex = hcbd_pkg::hex_value(i_byte);

    always_comb begin
        n_phase = r_phase;
        n_size  = r_size;
        n_err   = r_err;
        res     = '0;
        case (r_phase)
            hcbd_pkg::PH_FIRST: begin
                if (!hex[4]) begin
                    n_size  = SIZE_BITS'(hex[3:0]);
                    n_phase = hcbd_pkg::PH_SIZE;
                end else begin
                    n_err   = hcbd_pkg::ERR_SIZE_MISS;
                    n_phase = hcbd_pkg::PH_ERROR;
                end
            end
            hcbd_pkg::PH_SIZE: begin
                if (i_byte == hcbd_pkg::CH_CR) begin
                    n_phase = hcbd_pkg::PH_SIZE_CR;
                end else if (!hex[4]) begin
                    if (r_size[SIZE_BITS-1 -: 4] != 4'd0) begin
                        n_err   = hcbd_pkg::ERR_SIZE_OVF;
                        n_phase = hcbd_pkg::PH_ERROR;
                    end else begin
                        n_size = {r_size[SIZE_BITS-5:0], hex[3:0]};
                    end
                end else begin
                    n_err   = hcbd_pkg::ERR_SIZE_CHAR;
                    n_phase = hcbd_pkg::PH_ERROR;
                end
            end
            hcbd_pkg::PH_SIZE_CR: begin
                if (i_byte == hcbd_pkg::CH_LF) begin
                    n_phase = (r_size != '0) ? hcbd_pkg::PH_CHUNK : hcbd_pkg::PH_LAST_LF;
                end else begin
                    n_err   = hcbd_pkg::ERR_CR_NO_LF;
                    n_phase = hcbd_pkg::PH_ERROR;
                end
            end
            hcbd_pkg::PH_CHUNK: begin
                res.data_valid = 1'b1;
                res.data_byte  = i_byte;
                n_size         = r_size - SIZE_BITS'(1);
                if (r_size == SIZE_BITS'(1)) begin
                    res.chunk_end = 1'b1;
                    n_phase       = hcbd_pkg::PH_DATA_END;
                end
            end
            hcbd_pkg::PH_DATA_END: begin
                if (i_byte == hcbd_pkg::CH_CR) begin
                    n_phase = hcbd_pkg::PH_DATA_CR;
                end else begin
                    n_err   = hcbd_pkg::ERR_NO_DATA_CR;
                    n_phase = hcbd_pkg::PH_ERROR;
                end
            end
            hcbd_pkg::PH_DATA_CR: begin
                if (i_byte == hcbd_pkg::CH_LF) begin
                    n_phase = hcbd_pkg::PH_FIRST;
                end else begin
                    n_err   = hcbd_pkg::ERR_CR_NO_LF;
                    n_phase = hcbd_pkg::PH_ERROR;
                end
            end
            hcbd_pkg::PH_LAST_LF: begin
                if (i_byte == hcbd_pkg::CH_CR) begin
                    n_phase = hcbd_pkg::PH_LAST_CR;
                end else begin
                    n_err   = hcbd_pkg::ERR_NO_LAST_CR;
                    n_phase = hcbd_pkg::PH_ERROR;
                end
            end
            hcbd_pkg::PH_LAST_CR: begin
                if (i_byte == hcbd_pkg::CH_LF) begin
                    res.body_done = 1'b1;
                    n_phase       = hcbd_pkg::PH_DONE;
                end else begin
                    n_err   = hcbd_pkg::ERR_CR_NO_LF;
                    n_phase = hcbd_pkg::PH_ERROR;
                end
            end
            hcbd_pkg::PH_DONE: begin
                res.ignored   = 1'b1;
                res.body_done = 1'b1;
            end
            default: begin
                res.ignored = 1'b1;
                n_phase     = hcbd_pkg::PH_ERROR;
            end
        endcase
        res.error_code = n_err;
    end

    assign o_result = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= hcbd_pkg::PH_FIRST;
            r_size  <= '0;
            r_err   <= hcbd_pkg::ERR_NONE;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_size  <= n_size;
            r_err   <= n_err;
        end
    end

    a_error_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == hcbd_pkg::PH_ERROR |=> r_phase == hcbd_pkg::PH_ERROR)
        else $error("error phase left before reset");

    a_chunk_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == hcbd_pkg::PH_CHUNK |-> r_size != '0)
        else $error("payload phase with zero remaining count");

    a_payload_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res.data_valid |-> (res.error_code == hcbd_pkg::ERR_NONE && !res.ignored
                            && !res.body_done))
        else $error("payload word carries status");

    a_end_in_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res.chunk_end |-> res.data_valid)
        else $error("chunk end outside payload");

    a_done_no_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res.body_done |-> res.error_code == hcbd_pkg::ERR_NONE)
        else $error("done together with error");

endmodule

@@ rtl/core/hcbd_out_reg.sv @@
// Result register of the chunked body decoder.
// Holds one result word until taken and packs it onto the master stream; uses hcbd_pkg.
module hcbd_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  hcbd_pkg::t_result i_result,
    output logic              o_advance,
    output logic              o_tvalid,
    input  logic              i_tready,
    output logic [15:0]       o_tdata,
    output logic [1:0]        o_tuser,
    output logic              o_tlast
);

    logic              r_valid;
    hcbd_pkg::t_result r_res;

    assign o_advance = !r_valid || i_tready;
    assign o_tvalid  = r_valid;
    assign o_tdata   = {4'd0, r_res.error_code, r_res.body_done, r_res.data_byte};
    assign o_tuser   = {r_res.ignored, r_res.data_valid};
    assign o_tlast   = r_res.chunk_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_advance) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance && i_valid) begin
            r_res <= i_result;
        end
    end

endmodule

@@ rtl/core/http_chunked_body_decoder.sv @@
// HTTP/1.1 chunked body decoder: one raw byte in, one result word out per byte.
// The result word is registered: the byte passes the input register, the parser step, then the result register.
// Throughput: one byte per cycle while the master stream takes results; the parser step sits between the two registers.
// Reset (synchronous, active low) returns to expecting the first size digit,
// clears size and error, and empties both registers.
// Depends on hcbd_pkg, hcbd_in_stage, hcbd_fsm and hcbd_out_reg.
module http_chunked_body_decoder #(
    parameter int SIZE_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,  // [7:0] in_byte
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,  // [7:0] data_byte, [8] body_done, [11:9] error_code
    output logic [1:0]  o_m_axis_tuser,  // [0] data_valid, [1] ignored
    output logic        o_m_axis_tlast   // chunk_end
);

    logic              advance;
    logic              st_valid;
    logic [7:0]        st_byte;
    hcbd_pkg::t_result result;

    hcbd_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_axis_tvalid),
        .i_byte    (i_s_axis_tdata),
        .o_ready   (o_s_axis_tready),
        .i_advance (advance),
        .o_valid   (st_valid),
        .o_byte    (st_byte)
    );

    hcbd_fsm #(
        .SIZE_BITS (SIZE_BITS)
    ) u_fsm (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (st_valid && advance),
        .i_byte   (st_byte),
        .o_result (result)
    );

    hcbd_out_reg u_out (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (st_valid),
        .i_result  (result),
        .o_advance (advance),
        .o_tvalid  (o_m_axis_tvalid),
        .i_tready  (i_m_axis_tready),
        .o_tdata   (o_m_axis_tdata),
        .o_tuser   (o_m_axis_tuser),
        .o_tlast   (o_m_axis_tlast)
    );

endmodule
